[design/ptt_pkg.sv]
package ptt_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		FN_CREATE  = 2'd0,
		FN_CANCEL  = 2'd1,
		FN_RESTART = 2'd2,
		FN_TICK    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_CREATED   = 3'd0,
		ST_ZERO_PER  = 3'd1,
		ST_FULL      = 3'd2,
		ST_CANCELLED = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_RESTARTED = 3'd5,
		ST_FIRED     = 3'd6,
		ST_TICK_DONE = 3'd7
	} status_t;

	typedef struct packed {
		func_t        func;
		logic [31:0]  interval_us;
		logic         single_fire;
		logic [15:0]  context_tag;
		logic [31:0]  timer_ref;
		logic [63:0]  now_us;
	} req_t;

	typedef struct packed {
		status_t      status;
		logic [31:0]  timer_id;
		logic [15:0]  fired_tag;
		logic [4:0]   active_count;
		logic         last;
	} rsp_t;

endpackage

[design/ptt_queue.sv]
module ptt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ptt_pkg::req_t req,
	output logic          deq_valid,
	input  logic          deq_ready,
	output ptt_pkg::req_t deq
);

	localparam int PTR_W = (ptt_pkg::QUEUE_DEPTH > 1) ? $clog2(ptt_pkg::QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(ptt_pkg::QUEUE_DEPTH + 1);

	ptt_pkg::req_t     mem_q [ptt_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [FILL_W-1:0] fill_q;
	logic              push;
	logic              pop;

	assign req_ready = (fill_q != FILL_W'(ptt_pkg::QUEUE_DEPTH));
	assign deq_valid = (fill_q != '0);
	assign deq       = mem_q[rd_q];
	assign push      = req_valid && req_ready;
	assign pop       = deq_valid && deq_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(ptt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(ptt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= req;
		end
	end

endmodule

[design/ptt_engine.sv]
module ptt_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          deq_valid,
	output logic          deq_ready,
	input  ptt_pkg::req_t deq,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ptt_pkg::rsp_t rsp
);

	localparam int IW = ptt_pkg::IDX_W;
	localparam int CW = ptt_pkg::CNT_W;
	localparam int N  = ptt_pkg::SLOT_COUNT;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_END
	} state_t;

	state_t          state_q;
	ptt_pkg::req_t   item_q;
	logic [IW-1:0]   idx_q;
	logic [CW-1:0]   cnt_q;
	logic [31:0]     fresh_q;
	logic [N-1:0]    active_q;
	logic [31:0]     ident_q  [N];
	logic [31:0]     period_q [N];
	logic [63:0]     due_q    [N];
	logic [N-1:0]    once_q;
	logic [15:0]     tag_q    [N];
	logic            rsp_valid_q;
	ptt_pkg::rsp_t   rsp_q;

	logic            out_free;
	logic            is_last_slot;
	logic            cur_act;
	logic [63:0]     cur_due;
	logic [63:0]     now_plus;
	logic [63:0]     due_plus;
	logic [63:0]     due_next;
	logic            hit;
	logic            fire;

	assign out_free     = !rsp_valid_q || rsp_ready;
	assign deq_ready    = (state_q == S_IDLE) && out_free;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;
	assign is_last_slot = (idx_q == IW'(N - 1));
	assign cur_act      = active_q[idx_q];
	assign cur_due      = due_q[idx_q];
	assign now_plus     = item_q.now_us + {32'd0, period_q[idx_q]};
	assign due_plus     = cur_due + {32'd0, period_q[idx_q]};
	assign due_next     = (due_plus < item_q.now_us) ? now_plus : due_plus;
	assign hit          = cur_act && (ident_q[idx_q] == item_q.timer_ref);
	assign fire         = cur_act && (cur_due != '0) && (item_q.now_us >= cur_due);

	// sequencer: one slot per cycle, stalls while the result register is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			fresh_q     <= 32'd1;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (deq_valid && out_free) begin
						idx_q <= '0;
						if (deq.func == ptt_pkg::FN_CREATE && deq.interval_us == '0) begin
							rsp_valid_q <= 1'b1;
							rsp_q <= '{ptt_pkg::ST_ZERO_PER, 32'd0, 16'd0, 5'(cnt_q), 1'b1};
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (out_free) begin
						idx_q <= idx_q + 1'b1;
						unique case (item_q.func)
							ptt_pkg::FN_CREATE: begin
								if (!cur_act) begin
									active_q[idx_q] <= 1'b1;
									cnt_q           <= cnt_q + 1'b1;
									fresh_q         <= fresh_q + 1'b1;
									rsp_valid_q     <= 1'b1;
									rsp_q <= '{ptt_pkg::ST_CREATED, fresh_q, 16'd0,
										5'(cnt_q + 1'b1), 1'b1};
									state_q <= S_IDLE;
								end else if (is_last_slot) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= '{ptt_pkg::ST_FULL, 32'd0, 16'd0, 5'(cnt_q), 1'b1};
									state_q <= S_IDLE;
								end
							end
							ptt_pkg::FN_CANCEL, ptt_pkg::FN_RESTART: begin
								if (hit) begin
									rsp_valid_q <= 1'b1;
									state_q     <= S_IDLE;
									if (item_q.func == ptt_pkg::FN_CANCEL) begin
										active_q[idx_q] <= 1'b0;
										cnt_q           <= cnt_q - 1'b1;
										rsp_q <= '{ptt_pkg::ST_CANCELLED, item_q.timer_ref, 16'd0,
											5'(cnt_q - 1'b1), 1'b1};
									end else begin
										rsp_q <= '{ptt_pkg::ST_RESTARTED, item_q.timer_ref, 16'd0,
											5'(cnt_q), 1'b1};
									end
								end else if (is_last_slot) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= '{ptt_pkg::ST_NOT_FOUND, 32'd0, 16'd0, 5'(cnt_q), 1'b1};
									state_q <= S_IDLE;
								end
							end
							ptt_pkg::FN_TICK: begin
								if (fire) begin
									rsp_valid_q <= 1'b1;
									if (once_q[idx_q]) begin
										active_q[idx_q] <= 1'b0;
										cnt_q           <= cnt_q - 1'b1;
										rsp_q <= '{ptt_pkg::ST_FIRED, ident_q[idx_q], tag_q[idx_q],
											5'(cnt_q - 1'b1), 1'b0};
									end else begin
										rsp_q <= '{ptt_pkg::ST_FIRED, ident_q[idx_q], tag_q[idx_q],
											5'(cnt_q), 1'b0};
									end
									if (is_last_slot) begin
										state_q <= S_END;
									end
								end else if (is_last_slot) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= '{ptt_pkg::ST_TICK_DONE, 32'd0, 16'd0, 5'(cnt_q), 1'b1};
									state_q <= S_IDLE;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_END: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q <= '{ptt_pkg::ST_TICK_DONE, 32'd0, 16'd0, 5'(cnt_q), 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item latch and slot payload (reads gated by the active bits)
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && deq_valid && out_free) begin
			item_q <= deq;
		end
		if (state_q == S_SCAN && out_free) begin
			if (item_q.func == ptt_pkg::FN_CREATE && !cur_act) begin
				ident_q[idx_q]  <= fresh_q;
				period_q[idx_q] <= item_q.interval_us;
				due_q[idx_q]    <= '0;
				once_q[idx_q]   <= item_q.single_fire;
				tag_q[idx_q]    <= item_q.context_tag;
			end else if (item_q.func == ptt_pkg::FN_RESTART && hit) begin
				due_q[idx_q] <= now_plus;
			end else if (item_q.func == ptt_pkg::FN_TICK && cur_act) begin
				if (cur_due == '0) begin
					due_q[idx_q] <= now_plus;
				end else if (fire && !once_q[idx_q]) begin
					due_q[idx_q] <= due_next;
				end
			end
		end
	end

	a_cnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == $countones(active_q))
		else $error("active count out of step with active bits");

	a_end_is_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_END) |-> (item_q.func == ptt_pkg::FN_TICK))
		else $error("closing state entered outside a tick");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("result dropped or changed while waiting");

endmodule

[design/periodic_timer_table_unit.sv]
// Timer table with 16 slots. Requests go into a two-entry queue; a sequencer
// behind it walks the slots one per cycle. Create, cancel and restart stop at
// a free or matching slot or the last one; zero period answers with no scan.
// A tick walks all slots and ends with a closing result, sent from a closing
// state if the last slot fires. Each result waits in the output register
// until taken; the walk stalls on it. New requests may be queued meanwhile.
module periodic_timer_table_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ptt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ptt_pkg::rsp_t rsp
);

	logic          deq_valid;
	logic          deq_ready;
	ptt_pkg::req_t deq;

	ptt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq       (deq)
	);

	ptt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq       (deq),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
